[design/pts_pkg.sv]
package pts_pkg;

    localparam int SlotCount = 256;
    localparam int SlotW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
    localparam int AddrLimit = (SlotCount < 256) ? SlotCount : 256;
    localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

    // operation codes
    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_SETTIME = 3'd1;
    localparam logic [2:0] OP_GETTIME = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SLOT = 3'd1;
    localparam logic [2:0] ST_BAD_CLK  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_WOULD_BLK = 3'd4;

    // clock ids
    localparam logic [3:0] CLK_REALTIME   = 4'd0;
    localparam logic [3:0] CLK_MONOTONIC  = 4'd1;
    localparam logic [3:0] CLK_BOOT       = 4'd7;
    localparam logic [3:0] CLK_RT_ALARM   = 4'd8;
    localparam logic [3:0] CLK_BOOT_ALARM = 4'd9;

    // configuration register indexes
    localparam logic [7:0] CFG_RT_OFFSET  = 8'd0;
    localparam logic [7:0] CFG_START_TIME = 8'd1;

    typedef enum logic [2:0] {
        K_CREATE,
        K_BAD_CLK,
        K_SLOT_OP,
        K_TICK,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  op;
        logic [7:0]  slot;
        logic [3:0]  clock_id;
        logic        opt;
        logic [63:0] value;
        logic [63:0] period;
        logic [63:0] raw;
    } item_t;

    typedef struct packed {
        logic        rt;
        logic        nb;
        logic        armed;
        logic [63:0] expiry;
        logic [63:0] period;
        logic [31:0] pending;
    } row_t;

endpackage

[design/pts_front.sv]
module pts_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [2:0]      s_op,
    input  logic [207:0]    s_data,
    output logic            q_valid,
    output pts_pkg::item_t  q_item,
    input  logic            q_pop
);

    pts_pkg::item_t q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       clk_ok;
    pts_pkg::item_t in_item;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    // classify the incoming beat
    always_comb begin
        clk_ok = (s_data[11:8] == pts_pkg::CLK_REALTIME) ||
                 (s_data[11:8] == pts_pkg::CLK_MONOTONIC) ||
                 (s_data[11:8] == pts_pkg::CLK_BOOT) ||
                 (s_data[11:8] == pts_pkg::CLK_RT_ALARM) ||
                 (s_data[11:8] == pts_pkg::CLK_BOOT_ALARM);
        in_item.op       = s_op;
        in_item.slot     = s_data[7:0];
        in_item.clock_id = s_data[11:8];
        in_item.opt      = s_data[12];
        in_item.value    = s_data[76:13];
        in_item.period   = s_data[140:77];
        in_item.raw      = s_data[204:141];
        unique case (s_op)
            pts_pkg::OP_CREATE:  in_item.kind = clk_ok ? pts_pkg::K_CREATE : pts_pkg::K_BAD_CLK;
            pts_pkg::OP_SETTIME,
            pts_pkg::OP_GETTIME,
            pts_pkg::OP_READ:    in_item.kind = pts_pkg::K_SLOT_OP;
            pts_pkg::OP_TICK:    in_item.kind = pts_pkg::K_TICK;
            default:             in_item.kind = pts_pkg::K_NOP;
        endcase
    end

    // store the beat
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

[design/pts_div.sv]
module pts_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);

    logic [64:0] rem_reg;
    logic [63:0] dq_reg;
    logic [63:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] trial;
    logic [64:0] diff;

    assign trial     = {rem_reg[63:0], dq_reg[63]};
    assign diff      = trial - {1'b0, dvs_reg};
    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg[63:0];

    // one quotient bit per cycle, restoring
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
                rem_reg  <= 65'd0;
                dq_reg   <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                if (!diff[64]) begin
                    rem_reg <= diff;
                    dq_reg  <= {dq_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    dq_reg  <= {dq_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[design/pts_back.sv]
module pts_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_index,
    input  logic [63:0]     cfg_data,
    input  logic            q_valid,
    input  pts_pkg::item_t  q_item,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [2:0]      m_status,
    output logic [167:0]    m_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_TSCAN, S_RD, S_NOW, S_EVAL, S_DIV, S_LAST, S_STEP, S_FIN, S_DONE
    } state_t;

    localparam int SlotW_L = pts_pkg::SlotW;
    localparam logic [SlotW_L-1:0] LastIdx = SlotW_L'(pts_pkg::AddrLimit - 1);

    state_t state_reg;
    pts_pkg::item_t item_reg;
    logic [SlotW_L-1:0] idx_reg;
    logic [pts_pkg::SlotCount-1:0] used_reg;
    logic [63:0] rt_off_reg, start_reg;

    pts_pkg::row_t mem [pts_pkg::SlotCount];
    pts_pkg::row_t rd_data_reg;
    logic          mem_we_reg;
    logic [SlotW_L-1:0] mem_waddr_reg;
    pts_pkg::row_t mem_wdata_reg;

    logic        rt_w_reg, nb_w_reg, arm_w_reg;
    logic [63:0] exp_w_reg, per_w_reg, now_reg, d_reg;
    logic [31:0] pend_w_reg, n32_reg, total_reg;

    logic [2:0]  res_status_reg;
    logic [7:0]  res_slot_reg;
    logic [63:0] res_time_reg, res_int_reg;
    logic [31:0] res_cnt_reg;

    logic        m_valid_reg;
    logic [2:0]  m_status_reg;
    logic [167:0] m_data_reg;

    logic        div_start, div_done;
    logic [63:0] div_q, div_r;
    logic [15:0] slot_ext;
    logic        slot_in_range;
    logic        is_settime;
    logic        res_load;
    logic [64:0] step_sum;
    logic [32:0] pend_sum, tot_sum;
    logic [31:0] pend_sat, tot_sat;

    assign cfg_ready = 1'b1;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign m_tvalid  = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_data    = m_data_reg;
    assign slot_ext  = {8'd0, q_item.slot};
    assign slot_in_range = ({8'd0, q_item.slot} < 16'(pts_pkg::AddrLimit));
    assign is_settime = (item_reg.kind == pts_pkg::K_SLOT_OP) &&
                        (item_reg.op == pts_pkg::OP_SETTIME);
    assign res_load  = (state_reg == S_DONE) && (!m_valid_reg || m_tready);
    assign div_start = (state_reg == S_EVAL) && (item_reg.kind != pts_pkg::K_SLOT_OP ||
                       item_reg.op == pts_pkg::OP_READ) && arm_w_reg &&
                       !(exp_w_reg > now_reg) && (per_w_reg != 64'd0);
    assign step_sum  = {1'b0, exp_w_reg} + {1'b0, per_w_reg};
    assign pend_sum  = {1'b0, pend_w_reg} + {1'b0, n32_reg};
    assign pend_sat  = pend_sum[32] ? pts_pkg::CntMax : pend_sum[31:0];
    assign tot_sum   = {1'b0, total_reg} + {1'b0, n32_reg};
    assign tot_sat   = tot_sum[32] ? pts_pkg::CntMax : tot_sum[31:0];

    pts_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (now_reg - exp_w_reg),
        .divisor   (per_w_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we_reg) begin
            mem[mem_waddr_reg] <= mem_wdata_reg;
        end
        rd_data_reg <= mem[idx_reg];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_off_reg <= 64'd0;
            start_reg  <= 64'd0;
        end else if (cfg_valid) begin
            if (cfg_index == pts_pkg::CFG_RT_OFFSET) rt_off_reg <= cfg_data;
            if (cfg_index == pts_pkg::CFG_START_TIME) start_reg <= cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            mem_we_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            mem_we_reg  <= ((state_reg == S_SCAN) && !used_reg[idx_reg]) ||
                           ((state_reg == S_EVAL) && is_settime) ||
                           (state_reg == S_FIN);
            m_valid_reg <= res_load || (m_valid_reg && !m_tready);
            unique case (state_reg)
                S_IDLE: begin
                    res_slot_reg   <= 8'd0;
                    res_time_reg   <= 64'd0;
                    res_int_reg    <= 64'd0;
                    res_cnt_reg    <= 32'd0;
                    total_reg      <= 32'd0;
                    if (q_valid) begin
                        item_reg <= q_item;
                        unique case (q_item.kind)
                            pts_pkg::K_CREATE: begin
                                idx_reg        <= '0;
                                res_status_reg <= pts_pkg::ST_OK;
                                state_reg      <= S_SCAN;
                            end
                            pts_pkg::K_BAD_CLK: begin
                                res_status_reg <= pts_pkg::ST_BAD_CLK;
                                state_reg      <= S_DONE;
                            end
                            pts_pkg::K_SLOT_OP: begin
                                idx_reg <= slot_ext[SlotW_L-1:0];
                                if (!slot_in_range || !used_reg[slot_ext[SlotW_L-1:0]]) begin
                                    res_status_reg <= pts_pkg::ST_BAD_SLOT;
                                    state_reg      <= S_DONE;
                                end else begin
                                    res_status_reg <= pts_pkg::ST_OK;
                                    state_reg      <= S_RD;
                                end
                            end
                            pts_pkg::K_TICK: begin
                                idx_reg        <= '0;
                                res_status_reg <= pts_pkg::ST_OK;
                                state_reg      <= S_TSCAN;
                            end
                            default: begin
                                res_status_reg <= pts_pkg::ST_OK;
                                state_reg      <= S_DONE;
                            end
                        endcase
                    end
                end
                // find the lowest free slot
                S_SCAN: begin
                    if (!used_reg[idx_reg]) begin
                        used_reg[idx_reg]  <= 1'b1;
                        mem_waddr_reg <= idx_reg;
                        mem_wdata_reg <= '{rt: (item_reg.clock_id == pts_pkg::CLK_REALTIME ||
                                                item_reg.clock_id == pts_pkg::CLK_RT_ALARM),
                                           nb: item_reg.opt, armed: 1'b0, expiry: 64'd0,
                                           period: 64'd0, pending: 32'd0};
                        res_slot_reg  <= 8'(idx_reg);
                        state_reg     <= S_DONE;
                    end else if (idx_reg == LastIdx) begin
                        res_status_reg <= pts_pkg::ST_FULL;
                        state_reg      <= S_DONE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                // walk used slots for a tick
                S_TSCAN: begin
                    if (used_reg[idx_reg]) begin
                        state_reg <= S_RD;
                    end else if (idx_reg == LastIdx) begin
                        res_cnt_reg <= total_reg;
                        state_reg   <= S_DONE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_RD: state_reg <= S_NOW;
                // load the row and form the slot's clock time
                S_NOW: begin
                    rt_w_reg   <= rd_data_reg.rt;
                    nb_w_reg   <= rd_data_reg.nb;
                    exp_w_reg  <= rd_data_reg.expiry;
                    per_w_reg  <= rd_data_reg.period;
                    pend_w_reg <= rd_data_reg.pending;
                    arm_w_reg  <= rd_data_reg.armed;
                    n32_reg    <= 32'd0;
                    now_reg    <= rd_data_reg.rt ? item_reg.raw + rt_off_reg
                                                 : item_reg.raw - start_reg;
                    state_reg  <= S_EVAL;
                end
                S_EVAL: begin
                    if (is_settime) begin
                        if (arm_w_reg) begin
                            res_time_reg <= exp_w_reg;
                            res_int_reg  <= per_w_reg;
                        end
                        mem_waddr_reg <= idx_reg;
                        if (item_reg.value == 64'd0) begin
                            mem_wdata_reg <= '{rt: rt_w_reg, nb: nb_w_reg, armed: 1'b0,
                                               expiry: exp_w_reg, period: per_w_reg,
                                               pending: 32'd0};
                        end else begin
                            mem_wdata_reg <= '{rt: rt_w_reg, nb: nb_w_reg, armed: 1'b1,
                                               expiry: item_reg.opt ? item_reg.value
                                                                    : now_reg + item_reg.value,
                                               period: item_reg.period, pending: 32'd0};
                        end
                        state_reg <= S_DONE;
                    end else if (item_reg.kind == pts_pkg::K_SLOT_OP &&
                                 item_reg.op == pts_pkg::OP_GETTIME) begin
                        if (arm_w_reg) begin
                            res_time_reg <= (exp_w_reg > now_reg) ? exp_w_reg - now_reg : 64'd0;
                            res_int_reg  <= per_w_reg;
                        end
                        state_reg <= S_DONE;
                    end else if (!arm_w_reg || exp_w_reg > now_reg) begin
                        state_reg <= S_FIN;
                    end else if (per_w_reg == 64'd0) begin
                        n32_reg   <= 32'd1;
                        arm_w_reg <= 1'b0;
                        state_reg <= S_FIN;
                    end else begin
                        d_reg     <= now_reg - exp_w_reg;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) state_reg <= S_LAST;
                end
                // last expiry not after now, and the count
                S_LAST: begin
                    exp_w_reg <= exp_w_reg + (d_reg - div_r);
                    n32_reg   <= (div_q >= {32'd0, pts_pkg::CntMax}) ? pts_pkg::CntMax
                                                                     : div_q[31:0] + 32'd1;
                    state_reg <= S_STEP;
                end
                // step one period past now, or disarm on overflow
                S_STEP: begin
                    if (step_sum[64]) arm_w_reg <= 1'b0;
                    else exp_w_reg <= step_sum[63:0];
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    mem_waddr_reg <= idx_reg;
                    if (item_reg.kind == pts_pkg::K_TICK) begin
                        mem_wdata_reg <= '{rt: rt_w_reg, nb: nb_w_reg, armed: arm_w_reg,
                                           expiry: exp_w_reg, period: per_w_reg,
                                           pending: pend_sat};
                        total_reg <= tot_sat;
                        if (idx_reg == LastIdx) begin
                            res_cnt_reg <= tot_sat;
                            state_reg   <= S_DONE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_TSCAN;
                        end
                    end else begin
                        mem_wdata_reg <= '{rt: rt_w_reg, nb: nb_w_reg, armed: arm_w_reg,
                                           expiry: exp_w_reg, period: per_w_reg,
                                           pending: 32'd0};
                        if (pend_sat == 32'd0 && nb_w_reg) res_status_reg <= pts_pkg::ST_WOULD_BLK;
                        else res_cnt_reg <= pend_sat;
                        state_reg <= S_DONE;
                    end
                end
                // hand the result to the output register
                S_DONE: begin
                    if (res_load) begin
                        m_status_reg <= res_status_reg;
                        m_data_reg   <= {res_cnt_reg, res_int_reg, res_time_reg, res_slot_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> state_reg == S_DIV)
        else $error("divider started outside catch-up");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && (!m_valid_reg || m_tready)) |=> m_valid_reg)
        else $error("result not loaded");

    a_mem_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we_reg |-> ($past(state_reg) == S_SCAN || $past(state_reg) == S_EVAL ||
                        $past(state_reg) == S_FIN))
        else $error("unexpected slot memory write");

endmodule

[design/periodic_timer_slot_bank_top.sv]
// channel  direction  handshake              payload
// s_       in         s_tvalid / s_tready    s_tuser op, s_tdata item fields
// m_       out        m_tvalid / m_tready    m_tuser status, m_tdata result fields
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Create scans one slot a cycle, from the lowest slot up to the first free one.
// Settime and gettime finish without the divider; read uses it when a periodic slot is overdue.
// Tick walks every slot and uses the shared divider for each overdue periodic slot.
// A two-beat input queue takes items while the back end works or the result stalls.
// Reset is synchronous active low and clears the slot in-use bits at once.
module periodic_timer_slot_bank_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [2:0]    s_tuser,   // operation
    input  logic [207:0]  s_tdata,   // slot, clock_id, option_bit, first_expiry, period_ns, raw_time_ns
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [2:0]    m_tuser,   // status
    output logic [167:0]  m_tdata,   // new_slot, time_ns, reload_ns, expiry_count
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    logic           q_valid;
    logic           q_pop;
    pts_pkg::item_t q_item;

    pts_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .s_data   (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    pts_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_status  (m_tuser),
        .m_data    (m_tdata)
    );

endmodule
